// ----- rtl/lfba_pkg.sv -----
// Shared types and constants of the locking FIFO bus arbiter.
`timescale 1ns / 1ps

package lfba_pkg;

  localparam int ID_W      = 3;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 9;
  localparam int MASK_W    = 8;
  localparam int BEATS_W   = 8;
  localparam int SLV_W     = 2;
  localparam int REG_NUM   = 8;
  localparam int REG_IDX_W = 3;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  // Address range registers, begin and end of each slave in turn.
  typedef logic [REG_NUM-1:0][ADDR_W-1:0] cfg_regs_t;

  // Control shared by every cell of the order queue.
  typedef struct packed {
    logic            append;
    logic            remove;
    logic            locked;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] owner;
  } q_ctl_t;

  // Handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic occ;
    logic hit;
  } q_fwd_t;

  // Handed from a cell to its left-hand neighbor.
  typedef struct packed {
    logic            occ;
    logic [ID_W-1:0] id;
  } q_bwd_t;

  // Outcome of the slave address decode.
  typedef struct packed {
    logic             hit;
    logic [SLV_W-1:0] slave;
  } dec_t;

endpackage

// ----- rtl/lfba_cell.sv -----
// One slot of the arrival-order queue; slots form a compacting shift chain.
`timescale 1ns / 1ps

module lfba_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  lfba_pkg::q_ctl_t ctl,
  input  lfba_pkg::q_fwd_t left_in,
  input  lfba_pkg::q_bwd_t right_in,
  output lfba_pkg::q_fwd_t right_out,
  output lfba_pkg::q_bwd_t left_out
);
  import lfba_pkg::*;

  logic            occ_r;
  logic            occ_nxt;
  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;
  logic            match;
  logic            hit_out;
  logic            shift;
  logic            place;

  // A slot at or after the removed entry takes its right neighbor's content.
  assign match   = ctl.locked && occ_r && (id_r == ctl.owner);
  assign hit_out = left_in.hit || match;
  assign shift   = ctl.remove && hit_out;
  // A new entry lands in the first empty slot.
  assign place   = ctl.append && !occ_r && left_in.occ;

  always_comb begin
    occ_nxt = occ_r;
    id_nxt  = id_r;
    if (shift) begin
      occ_nxt = right_in.occ;
      id_nxt  = right_in.id;
    end else if (place) begin
      occ_nxt = 1'b1;
      id_nxt  = ctl.new_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign right_out.occ = occ_r;
  assign right_out.hit = hit_out;
  assign left_out.occ  = occ_r;
  assign left_out.id   = id_r;

endmodule

// ----- rtl/lfba_dec.sv -----
// Slave address decoder; the lowest matching range wins.
`timescale 1ns / 1ps

module lfba_dec #(
  parameter int NUM_SLAVES = 4
) (
  input  logic [lfba_pkg::ADDR_W-1:0] addr,
  input  lfba_pkg::cfg_regs_t         regs,
  output lfba_pkg::dec_t              dec
);
  import lfba_pkg::*;

  always_comb begin
    dec.hit   = 1'b0;
    dec.slave = '0;
    for (int s = NUM_SLAVES - 1; s >= 0; s--) begin
      if (addr >= regs[2 * s] && addr <= regs[2 * s + 1]) begin
        dec.hit   = 1'b1;
        dec.slave = SLV_W'(s);
      end
    end
  end

endmodule

// ----- rtl/locking_fifo_bus_arbiter_unit.sv -----
// Top level of the locking FIFO bus arbiter with slave address decode.
//
// Usage: every beat on the in_ channel is either a master request
// (in_tuser low) or one bus clock tick (in_tuser high). A request stores
// the master's burst and queues its id in arrival order; a tick either
// counts down the running burst or grants the oldest queued master, or
// only the lock owner while the bus is locked. Exactly one result beat
// leaves on the out_ channel for every input beat, in order.
// The address range registers are written through cfg_wdata, cfg_addr and
// cfg_we while the arbiter is idle, a rule the user must keep that the
// block does not enforce; they take effect on the next beat. The result
// beat is registered on acceptance, and one beat can be accepted in every
// cycle while the output register is free or being taken. The queue search
// in the cell chain, the stored burst read and the decode are combinational.
// The result sits in an output register. When the receiver stalls, the
// held result blocks the input until it is taken, so no beat is lost.
// Reset (rst_n low at a clock edge) empties the queue, clears all pending
// marks, unlocks the bus, stops any burst and zeroes the range registers.
`timescale 1ns / 1ps

module locking_fifo_bus_arbiter_unit #(
  parameter int NUM_MASTERS = 8,
  parameter int NUM_SLAVES  = 4,
  parameter int MAX_BURST   = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [lfba_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [lfba_pkg::ADDR_W-1:0]    cfg_wdata,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata, from bit 0: master_id[2:0], addr[34:3], burst_len[43:35],
  // byte_mask[51:44], is_read[52], lock[53], zero pad [55:54].
  input  logic [55:0]                    in_tdata,
  // tuser: cmd (0 = request, 1 = tick).
  input  logic                           in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata, from bit 0: request_rejected[0], grant_valid[1],
  // grant_master[4:2], grant_slave[6:5], grant_addr[38:7],
  // grant_len[47:39], grant_read[48], grant_mask[56:49],
  // decode_error[57], done_valid[58], done_master[61:59], zero pad [63:62].
  output logic [63:0]                    out_tdata
);
  import lfba_pkg::*;

  localparam int IDX_W = (NUM_MASTERS > 1) ? $clog2(NUM_MASTERS) : 1;

  typedef struct packed {
    logic              rejected;
    logic              grant_valid;
    logic [ID_W-1:0]   grant_master;
    logic [SLV_W-1:0]  grant_slave;
    logic [ADDR_W-1:0] grant_addr;
    logic [LEN_W-1:0]  grant_len;
    logic              grant_read;
    logic [MASK_W-1:0] grant_mask;
    logic              decode_error;
    logic              done_valid;
    logic [ID_W-1:0]   done_master;
  } res_t;

  // Input beat fields.
  cmd_t              in_cmd;
  logic [ID_W-1:0]   in_master_id;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  in_burst_len;
  logic [MASK_W-1:0] in_byte_mask;
  logic              in_is_read;
  logic              in_lock;

  assign in_cmd       = cmd_t'(in_tuser);
  assign in_master_id = in_tdata[2:0];
  assign in_addr      = in_tdata[34:3];
  assign in_burst_len = in_tdata[43:35];
  assign in_byte_mask = in_tdata[51:44];
  assign in_is_read   = in_tdata[52];
  assign in_lock      = in_tdata[53];

  // Configuration and arbiter state.
  cfg_regs_t                     regs_r;
  logic [NUM_MASTERS-1:0]        pend_flag_r;
  logic [NUM_MASTERS-1:0]        pend_flag_nxt;
  logic [ADDR_W-1:0]             pend_addr_r [NUM_MASTERS];
  logic [LEN_W-1:0]              pend_len_r  [NUM_MASTERS];
  logic [MASK_W-1:0]             pend_mask_r [NUM_MASTERS];
  logic                          pend_read_r [NUM_MASTERS];
  logic                          pend_lock_r [NUM_MASTERS];
  logic                          bus_locked_r;
  logic                          bus_locked_nxt;
  logic [ID_W-1:0]               owner_r;
  logic [ID_W-1:0]               owner_nxt;
  logic [BEATS_W-1:0]            beats_left_r;
  logic [BEATS_W-1:0]            beats_left_nxt;
  logic                          running_r;
  logic                          running_nxt;
  logic                          out_valid_r;
  res_t                          res_r;
  res_t                          res_nxt;

  // Queue chain.
  q_ctl_t                        q_ctl;
  q_fwd_t                        fwd [NUM_MASTERS+1];
  q_bwd_t                        bwd [NUM_MASTERS+1];
  logic [NUM_MASTERS-1:0]        occ_vec;

  logic                          in_fire;
  logic                          is_req;
  logic                          is_tick;
  logic [IDX_W-1:0]              req_idx;
  logic                          id_bad;
  logic                          queue_full;
  logic                          queue_empty;
  logic                          req_ok;
  logic [LEN_W-1:0]              len_eff;
  logic                          grant;
  logic [ID_W-1:0]               grant_m;
  logic [IDX_W-1:0]              gm_idx;
  logic [IDX_W-1:0]              owner_idx;
  logic [BEATS_W-1:0]            grant_beats;
  logic                          run_done;
  dec_t                          dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_req    = in_fire && (in_cmd == CMD_REQUEST);
  assign is_tick   = in_fire && (in_cmd == CMD_TICK);

  // Request admission.
  assign req_idx     = IDX_W'(in_master_id);
  assign id_bad      = int'(in_master_id) >= NUM_MASTERS;
  assign queue_full  = bwd[NUM_MASTERS-1].occ;
  assign queue_empty = !bwd[0].occ;
  assign req_ok      = !id_bad && !pend_flag_r[req_idx] && !queue_full;

  // Zero length means one beat; anything above the maximum is clipped.
  always_comb begin
    len_eff = in_burst_len;
    if (in_burst_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(in_burst_len) > MAX_BURST) begin
      len_eff = LEN_W'(MAX_BURST);
    end
  end

  // Grant selection: the head of the queue, or the lock owner found by the
  // hit chain. With the bus unlocked the chain is seeded high, so the head
  // entry is always the one removed.
  assign grant       = is_tick && !running_r && !queue_empty && fwd[NUM_MASTERS].hit;
  assign grant_m     = bus_locked_r ? owner_r : bwd[0].id;
  assign gm_idx      = IDX_W'(grant_m);
  assign owner_idx   = IDX_W'(owner_r);
  assign grant_beats = BEATS_W'(pend_len_r[gm_idx] - LEN_W'(1));
  assign run_done    = is_tick && running_r && (beats_left_r <= BEATS_W'(1));

  assign q_ctl.append = is_req && req_ok;
  assign q_ctl.remove = grant;
  assign q_ctl.locked = bus_locked_r;
  assign q_ctl.new_id = in_master_id;
  assign q_ctl.owner  = owner_r;

  assign fwd[0].occ         = 1'b1;
  assign fwd[0].hit         = !bus_locked_r;
  assign bwd[NUM_MASTERS]   = '0;

  for (genvar i = 0; i < NUM_MASTERS; i++) begin : g_cell
    lfba_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (q_ctl),
      .left_in   (fwd[i]),
      .right_in  (bwd[i+1]),
      .right_out (fwd[i+1]),
      .left_out  (bwd[i])
    );
    assign occ_vec[i] = bwd[i].occ;
  end

  lfba_dec #(
    .NUM_SLAVES (NUM_SLAVES)
  ) u_dec (
    .addr (pend_addr_r[gm_idx]),
    .regs (regs_r),
    .dec  (dec)
  );

  // Next state and the result of the accepted beat.
  always_comb begin
    pend_flag_nxt  = pend_flag_r;
    bus_locked_nxt = bus_locked_r;
    owner_nxt      = owner_r;
    beats_left_nxt = beats_left_r;
    running_nxt    = running_r;
    res_nxt        = '0;

    if (is_req) begin
      if (req_ok) begin
        pend_flag_nxt[req_idx] = 1'b1;
      end else begin
        res_nxt.rejected = 1'b1;
      end
    end else if (is_tick) begin
      if (running_r) begin
        if (beats_left_r != '0) begin
          beats_left_nxt = beats_left_r - BEATS_W'(1);
        end
        if (run_done) begin
          running_nxt               = 1'b0;
          pend_flag_nxt[owner_idx]  = 1'b0;
          res_nxt.done_valid        = 1'b1;
          res_nxt.done_master       = owner_r;
        end
      end else if (grant) begin
        bus_locked_nxt       = pend_lock_r[gm_idx];
        owner_nxt            = grant_m;
        beats_left_nxt       = grant_beats;
        res_nxt.grant_valid  = 1'b1;
        res_nxt.grant_master = grant_m;
        res_nxt.grant_slave  = dec.slave;
        res_nxt.grant_addr   = pend_addr_r[gm_idx];
        res_nxt.grant_len    = pend_len_r[gm_idx];
        res_nxt.grant_read   = pend_read_r[gm_idx];
        res_nxt.grant_mask   = pend_mask_r[gm_idx];
        res_nxt.decode_error = !dec.hit;
        // A single-beat burst completes on its grant tick.
        if (grant_beats == '0) begin
          pend_flag_nxt[gm_idx] = 1'b0;
          res_nxt.done_valid    = 1'b1;
          res_nxt.done_master   = grant_m;
        end else begin
          running_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r       <= '0;
      pend_flag_r  <= '0;
      bus_locked_r <= 1'b0;
      owner_r      <= '0;
      beats_left_r <= '0;
      running_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        regs_r[cfg_addr] <= cfg_wdata;
      end
      pend_flag_r  <= pend_flag_nxt;
      bus_locked_r <= bus_locked_nxt;
      owner_r      <= owner_nxt;
      beats_left_r <= beats_left_nxt;
      running_r    <= running_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-master burst store and the result register carry no reset.
  always_ff @(posedge clk) begin
    if (is_req && req_ok) begin
      pend_addr_r[req_idx] <= in_addr;
      pend_len_r[req_idx]  <= len_eff;
      pend_mask_r[req_idx] <= in_byte_mask;
      pend_read_r[req_idx] <= in_is_read;
      pend_lock_r[req_idx] <= in_lock;
    end
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       res_r.done_master,
                       res_r.done_valid,
                       res_r.decode_error,
                       res_r.grant_mask,
                       res_r.grant_read,
                       res_r.grant_len,
                       res_r.grant_addr,
                       res_r.grant_slave,
                       res_r.grant_master,
                       res_r.grant_valid,
                       res_r.rejected};

`ifndef ASSERT_OFF
  // A running burst always has beats still to count.
  a_run_beats: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (beats_left_r != '0))
    else $error("burst running with no beats left");

  // The master owning a running burst stays pending until it completes.
  a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> pend_flag_r[owner_idx])
    else $error("running burst owner not marked pending");

  // Occupied queue slots stay packed toward the head.
  a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_vec & (occ_vec + 1'b1)) == '0)
    else $error("order queue has a gap");

  // A rejected request never carries a grant or a completion.
  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rejected) |-> !(res_r.grant_valid || res_r.done_valid))
    else $error("rejected request reports bus activity");
`endif

endmodule

// ----- dv/arbiter_checker.sv -----
// Checker for the locking FIFO bus arbiter: predicts every result beat and compares it.
`timescale 1ns / 1ps

module arbiter_checker #(
  parameter int NUM_MASTERS = 8,
  parameter int NUM_SLAVES  = 4,
  parameter int MAX_BURST   = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfba_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [lfba_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [55:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [63:0]                    out_tdata,
  output int                             fail_count,
  output int unsigned                    due_count
);
  import lfba_pkg::*;

  typedef struct packed {
    logic [1:0]        pad;
    logic              lock;
    logic              is_read;
    logic [MASK_W-1:0] byte_mask;
    logic [LEN_W-1:0]  burst_len;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   master_id;
  } bus_request_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [ID_W-1:0]   done_master;
    logic              done_valid;
    logic              decode_error;
    logic [MASK_W-1:0] grant_mask;
    logic              grant_read;
    logic [LEN_W-1:0]  grant_len;
    logic [ADDR_W-1:0] grant_addr;
    logic [SLV_W-1:0]  grant_slave;
    logic [ID_W-1:0]   grant_master;
    logic              grant_valid;
    logic              request_rejected;
  } arb_result_t;

  // Shadow of the arbiter state.
  logic [ADDR_W-1:0]  range_reg [REG_NUM];
  logic [ID_W-1:0]    arrival_ids [$];
  logic               waiting   [NUM_MASTERS];
  logic [ADDR_W-1:0]  burst_addr [NUM_MASTERS];
  logic [LEN_W-1:0]   burst_len [NUM_MASTERS];
  logic [MASK_W-1:0]  burst_mask [NUM_MASTERS];
  logic               burst_rd [NUM_MASTERS];
  logic               burst_lock [NUM_MASTERS];
  logic               bus_locked;
  logic [ID_W-1:0]    owner;
  logic [BEATS_W-1:0] beats_left;
  logic               burst_busy;

  arb_result_t awaited_results [$];
  arb_result_t want;

  // Works out the result of one input beat and advances the shadow state.
  function automatic arb_result_t arbitrate_beat(logic cmd_bit, bus_request_t req);
    arb_result_t      r;
    int               pos;
    logic [ID_W-1:0]  m;
    logic [LEN_W-1:0] len;
    r = '0;
    if (cmd_t'(cmd_bit) == CMD_REQUEST) begin
      if (req.master_id >= NUM_MASTERS || waiting[req.master_id] ||
          arrival_ids.size() >= NUM_MASTERS) begin
        r.request_rejected = 1'b1;
        return r;
      end
      len = req.burst_len;
      if (len == '0) len = LEN_W'(1);
      if (len > MAX_BURST) len = LEN_W'(MAX_BURST);
      waiting[req.master_id]    = 1'b1;
      burst_addr[req.master_id] = req.addr;
      burst_len[req.master_id]  = len;
      burst_mask[req.master_id] = req.byte_mask;
      burst_rd[req.master_id]   = req.is_read;
      burst_lock[req.master_id] = req.lock;
      arrival_ids.insert(arrival_ids.size(), req.master_id);
      return r;
    end

    if (burst_busy) begin
      if (beats_left != '0) beats_left = beats_left - 1'b1;
      if (beats_left == '0) begin
        burst_busy     = 1'b0;
        waiting[owner] = 1'b0;
        r.done_valid   = 1'b1;
        r.done_master  = owner;
      end
      return r;
    end

    if (arrival_ids.size() == 0) return r;

    // A locked bus only serves its owner, wherever it sits in the queue.
    pos = 0;
    if (bus_locked) begin
      pos = -1;
      foreach (arrival_ids[i]) begin
        if (pos < 0 && arrival_ids[i] == owner) pos = i;
      end
      if (pos < 0) return r;
    end
    m = arrival_ids[pos];
    arrival_ids.delete(pos);

    r.decode_error = 1'b1;
    for (int s = 0; s < NUM_SLAVES; s++) begin
      if (r.decode_error && burst_addr[m] >= range_reg[2*s] &&
          burst_addr[m] <= range_reg[2*s+1]) begin
        r.decode_error = 1'b0;
        r.grant_slave  = SLV_W'(s);
      end
    end

    bus_locked     = burst_lock[m];
    owner          = m;
    r.grant_valid  = 1'b1;
    r.grant_master = m;
    r.grant_addr   = burst_addr[m];
    r.grant_len    = burst_len[m];
    r.grant_read   = burst_rd[m];
    r.grant_mask   = burst_mask[m];

    beats_left = BEATS_W'(burst_len[m] - 1'b1);
    if (beats_left == '0) begin
      waiting[m]    = 1'b0;
      r.done_valid  = 1'b1;
      r.done_master = m;
    end else begin
      burst_busy = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $display("%0t %s: expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  task automatic compare_result(arb_result_t exp_r, arb_result_t act_r);
    check_field("request_rejected", exp_r.request_rejected, act_r.request_rejected);
    check_field("grant_valid", exp_r.grant_valid, act_r.grant_valid);
    check_field("grant_master", exp_r.grant_master, act_r.grant_master);
    check_field("grant_slave", exp_r.grant_slave, act_r.grant_slave);
    check_field("grant_addr", exp_r.grant_addr, act_r.grant_addr);
    check_field("grant_len", exp_r.grant_len, act_r.grant_len);
    check_field("grant_read", exp_r.grant_read, act_r.grant_read);
    check_field("grant_mask", exp_r.grant_mask, act_r.grant_mask);
    check_field("decode_error", exp_r.decode_error, act_r.decode_error);
    check_field("done_valid", exp_r.done_valid, act_r.done_valid);
    check_field("done_master", exp_r.done_master, act_r.done_master);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (range_reg[i]) range_reg[i] = '0;
      foreach (waiting[i]) waiting[i] = 1'b0;
      arrival_ids.delete();
      awaited_results.delete();
      bus_locked = 1'b0;
      owner      = '0;
      beats_left = '0;
      burst_busy = 1'b0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t result beat: expected none, got %h", $time, out_tdata);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          compare_result(want, arb_result_t'(out_tdata));
        end
      end
      if (cfg_we) range_reg[cfg_addr] = cfg_wdata;
      if (in_tvalid && in_tready)
        awaited_results.insert(awaited_results.size(),
                               arbitrate_beat(in_tuser, bus_request_t'(in_tdata)));
    end
    due_count <= awaited_results.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the locking FIFO bus arbiter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

// The top drives request and tick beats into the arbiter and toggles the
// receiver's ready; arbiter_checker sits beside the block, predicts every
// result beat and counts mismatches. The run is split into phases, and the
// slave address ranges are rewritten only between phases, after every
// outstanding result has come back.
module tb;
  import lfba_pkg::*;

  localparam int NUM_MASTERS      = 8;
  localparam int NUM_SLAVES       = 4;
  localparam int MAX_BURST        = 256;
  localparam int RESET_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 250000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS     = 264;
  localparam int RANDOM_PHASES    = 4;
  localparam int END_CYCLES       = 20;

  typedef enum {PLAN_RANDOM, PLAN_EDGES, PLAN_OVERLAP} range_plan_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_addr;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  // tdata, from bit 0: master_id[2:0], addr[34:3], burst_len[43:35],
  // byte_mask[51:44], is_read[52], lock[53], zero pad [55:54].
  logic [55:0]          in_tdata;
  // tuser: cmd (0 = request, 1 = tick).
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // tdata, from bit 0: request_rejected[0], grant_valid[1],
  // grant_master[4:2], grant_slave[6:5], grant_addr[38:7],
  // grant_len[47:39], grant_read[48], grant_mask[56:49],
  // decode_error[57], done_valid[58], done_master[61:59], zero pad [63:62].
  logic [63:0]          out_tdata;

  int                   fail_count;
  int unsigned          due_count;

  // Flow control knobs shared by the sender and the receiver processes.
  logic                 tx_stalls;
  logic                 rx_stalls;
  logic                 long_hold;

  // The testbench's own copy of the ranges, used to aim addresses at the
  // boundaries of the current map.
  logic [ADDR_W-1:0]    range_lo [NUM_SLAVES];
  logic [ADDR_W-1:0]    range_hi [NUM_SLAVES];

  locking_fifo_bus_arbiter_unit #(
    .NUM_MASTERS(NUM_MASTERS),
    .NUM_SLAVES (NUM_SLAVES),
    .MAX_BURST  (MAX_BURST)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  arbiter_checker #(
    .NUM_MASTERS(NUM_MASTERS),
    .NUM_SLAVES (NUM_SLAVES),
    .MAX_BURST  (MAX_BURST)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .due_count (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every task below is entered right after a rising edge and drives with
  // nonblocking assignments, so the block and the checker both see stable
  // values at the next edge.

  // Offers one beat and returns at the edge where it is accepted. tvalid is
  // left high so that a following beat can go out back to back; a random
  // gap may first drop it.
  task automatic send_beat(cmd_t cmd, logic [55:0] payload);
    if (tx_stalls && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic request(logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
                         logic [LEN_W-1:0] len, logic [MASK_W-1:0] mask,
                         logic rd, logic lk);
    send_beat(CMD_REQUEST, {2'b00, lk, rd, mask, len, addr, id});
  endtask

  // The fields of a tick are don't-care, so they carry random noise.
  task automatic tick();
    send_beat(CMD_TICK, {2'b00, 54'({$urandom, $urandom})});
  endtask

  // Stops offering beats and waits until every predicted result is back.
  // The first edge lets the checker count the beat accepted just now.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes begin and end of every slave range, register 2*s and 2*s+1.
  task automatic load_ranges();
    for (int s = 0; s < NUM_SLAVES; s++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_IDX_W'(2 * s);
      cfg_wdata <= range_lo[s];
      @(posedge clk);
      cfg_addr  <= REG_IDX_W'(2 * s + 1);
      cfg_wdata <= range_hi[s];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic plan_ranges(range_plan_t plan);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    case (plan)
      PLAN_EDGES: begin
        // A single-address range at the top, an empty range whose begin lies
        // past its end, one at address zero and the span between them.
        range_lo = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001};
        range_hi = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE};
      end
      PLAN_OVERLAP: begin
        // Every range covers the whole space, so slave 0 must always win.
        range_lo = '{default: '0};
        range_hi = '{default: '1};
      end
      default: begin
        for (int s = 0; s < NUM_SLAVES; s++) begin
          a = $urandom;
          b = $urandom;
          if ($urandom_range(0, 5) == 0) begin
            range_lo[s] = (a > b) ? a : b;
            range_hi[s] = (a > b) ? b : a;
          end else begin
            range_lo[s] = (a < b) ? a : b;
            range_hi[s] = (a < b) ? b : a;
          end
        end
      end
    endcase
    load_ranges();
  endtask

  // Addresses lean toward range boundaries and the ends of the space.
  function automatic logic [ADDR_W-1:0] pick_addr();
    int s = $urandom_range(0, NUM_SLAVES - 1);
    case ($urandom_range(0, 7))
      0:       return range_lo[s];
      1:       return range_hi[s];
      2:       return range_lo[s] - 1'b1;
      3:       return range_hi[s] + 1'b1;
      4:       return '0;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly short bursts so the queue keeps turning over; a length of zero
  // now and then to check that it is taken as one beat.
  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return LEN_W'($urandom_range(7, 24));
      default: return LEN_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 9) < 4)
      request(ID_W'($urandom_range(0, NUM_MASTERS - 1)), pick_addr(), pick_len(),
              MASK_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 5) == 0);
    else
      tick();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register fills and the block has to stall its input.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_TICK;
    in_tdata  = '0;
    tx_stalls = 1'b0;
    rx_stalls = 1'b0;
    long_hold = 1'b0;
    range_lo  = '{default: '0};
    range_hi  = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset map every range is just address zero. A tick on an
    // empty queue grants nothing; a single-beat burst shows grant and done
    // together; a zero length becomes one beat; the top address misses.
    tick();
    request(3'd0, 32'h0000_0000, 9'd1, 8'hFF, 1'b1, 1'b0);
    tick();
    request(3'd7, 32'hFFFF_FFFF, 9'd0, 8'h00, 1'b0, 1'b0);
    tick();
    drain();

    // A plain map with slave 2 overlapping slave 1 and the top address left
    // unmapped. Idling on both sides from here on.
    tx_stalls = 1'b1;
    rx_stalls = 1'b1;
    range_lo = '{32'h0000_0000, 32'h1000_0000, 32'h1800_0000, 32'h8000_0000};
    range_hi = '{32'h0FFF_FFFF, 32'h1FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
    load_ranges();

    // Master 1 takes a locked burst; its second request is refused while it
    // is pending. After completion the bus stays locked to master 1, so a
    // tick grants nothing although others wait. Master 1 then requests
    // again from the back of the queue, is served first and drops the lock.
    request(3'd1, 32'h1000_0000, 9'd3, 8'h0F, 1'b0, 1'b1);
    request(3'd1, 32'h0000_0040, 9'd2, 8'hF0, 1'b1, 1'b0);
    request(3'd2, 32'h8000_0000, 9'd2, 8'h3C, 1'b1, 1'b0);
    request(3'd3, 32'h1800_0000, 9'd1, 8'hC3, 1'b0, 1'b0);
    repeat (3) tick();
    tick();
    request(3'd1, 32'hFFFF_FFFF, 9'd1, 8'h81, 1'b0, 1'b0);
    tick();
    // Master 2 runs two beats; the completing tick must not grant master 3.
    repeat (2) tick();
    tick();

    // Longest burst: an over-range length is clamped to the maximum. While
    // it runs, more masters queue up (one of them locking) and the receiver
    // holds off for a long stretch, so the block backs up into its input.
    request(3'd4, 32'h7FFF_FFFF, 9'h1FF, 8'hA5, 1'b1, 1'b0);
    tick();
    request(3'd5, pick_addr(), 9'd2, 8'h5A, 1'b0, 1'b0);
    request(3'd6, pick_addr(), 9'd3, 8'h99, 1'b1, 1'b1);
    request(3'd0, pick_addr(), 9'd1, 8'h66, 1'b0, 1'b0);
    long_hold = 1'b1;
    repeat (MAX_BURST + 10) tick();

    // Random traffic under changing maps; the last phase runs without any
    // idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        1:       plan_ranges(PLAN_EDGES);
        2:       plan_ranges(PLAN_OVERLAP);
        default: plan_ranges(PLAN_RANDOM);
      endcase
      if (ph == RANDOM_PHASES - 1) begin
        tx_stalls = 1'b0;
        rx_stalls = 1'b0;
      end
      repeat (RANDOM_ITEMS / RANDOM_PHASES) random_item();
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
